// ===== design/triangle_normal_tangent_core_defines.svh =====
// Assertion macros shared by the triangle normal/tangent core
`ifndef TRIANGLE_NORMAL_TANGENT_CORE_DEFINES_SVH
`define TRIANGLE_NORMAL_TANGENT_CORE_DEFINES_SVH

// checked outside reset
`define TNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TNT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tnt_pkg.sv =====
// Shared types, operation table and constants for the triangle normal/tangent core
package tnt_pkg;

  // operand register codes
  localparam logic [3:0] OPD_E1X = 4'd0;
  localparam logic [3:0] OPD_E1Y = 4'd1;
  localparam logic [3:0] OPD_E1Z = 4'd2;
  localparam logic [3:0] OPD_E2X = 4'd3;
  localparam logic [3:0] OPD_E2Y = 4'd4;
  localparam logic [3:0] OPD_E2Z = 4'd5;
  localparam logic [3:0] OPD_DU1 = 4'd6;
  localparam logic [3:0] OPD_DV1 = 4'd7;
  localparam logic [3:0] OPD_DU2 = 4'd8;
  localparam logic [3:0] OPD_DV2 = 4'd9;
  localparam int         OPD_N   = 10;

  // accumulator codes
  localparam logic [2:0] ACC_CRX = 3'd0;
  localparam logic [2:0] ACC_CRY = 3'd1;
  localparam logic [2:0] ACC_CRZ = 3'd2;
  localparam logic [2:0] ACC_TGX = 3'd3;
  localparam logic [2:0] ACC_TGY = 3'd4;
  localparam logic [2:0] ACC_TGZ = 3'd5;
  localparam logic [2:0] ACC_DET = 3'd6;
  localparam int         ACC_N   = 7;

  // multiply-accumulate sequence
  localparam logic [3:0] OP_FIRST_DET   = 4'd0;
  localparam logic [3:0] OP_FIRST_CROSS = 4'd2;
  localparam logic [3:0] OP_LAST_CROSS  = 4'd7;
  localparam logic [3:0] OP_FIRST_TAN   = 4'd8;
  localparam logic [3:0] OP_LAST_TAN    = 4'd13;

  // normalization
  localparam int C_W         = 30;
  localparam int NORM_HI_BIT = 30;
  localparam int NORM_LO_BIT = 29;
  localparam int SQ_W        = 64;
  localparam int LEN_W       = 32;
  localparam int SQRT_STEPS  = 32;

  localparam logic [1:0] ST_AREA_ZERO = 2'b01;
  localparam logic [1:0] ST_DET_ZERO  = 2'b10;

  typedef struct packed {
    logic [2:0] dst;
    logic [3:0] a;
    logic [3:0] b;
    logic       sub;
  } opinfo_t;

  typedef struct packed {
    logic       cap0;
    logic       cap1;
    logic       cap2;
    logic       mac_load;
    logic       mac_step;
    logic [3:0] op;
    logic       norm_load;
    logic       norm_shr;
    logic       norm_shl;
    logic       sq_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       vsel;
    logic [1:0] idx;
    logic       out_load;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic det_neg;
    logic norm_zero;
    logic norm_hi;
    logic norm_lo;
  } sts_t;

  function automatic opinfo_t op_info(input logic [3:0] op);
    opinfo_t r;
    case (op)
      4'd0:    r = '{ACC_DET, OPD_DU1, OPD_DV2, 1'b0};
      4'd1:    r = '{ACC_DET, OPD_DU2, OPD_DV1, 1'b1};
      4'd2:    r = '{ACC_CRX, OPD_E1Y, OPD_E2Z, 1'b0};
      4'd3:    r = '{ACC_CRX, OPD_E1Z, OPD_E2Y, 1'b1};
      4'd4:    r = '{ACC_CRY, OPD_E1Z, OPD_E2X, 1'b0};
      4'd5:    r = '{ACC_CRY, OPD_E1X, OPD_E2Z, 1'b1};
      4'd6:    r = '{ACC_CRZ, OPD_E1X, OPD_E2Y, 1'b0};
      4'd7:    r = '{ACC_CRZ, OPD_E1Y, OPD_E2X, 1'b1};
      4'd8:    r = '{ACC_TGX, OPD_DV2, OPD_E1X, 1'b0};
      4'd9:    r = '{ACC_TGX, OPD_DV1, OPD_E2X, 1'b1};
      4'd10:   r = '{ACC_TGY, OPD_DV2, OPD_E1Y, 1'b0};
      4'd11:   r = '{ACC_TGY, OPD_DV1, OPD_E2Y, 1'b1};
      4'd12:   r = '{ACC_TGZ, OPD_DV2, OPD_E1Z, 1'b0};
      4'd13:   r = '{ACC_TGZ, OPD_DV1, OPD_E2Z, 1'b1};
      default: r = '{ACC_DET, OPD_E1X, OPD_E1X, 1'b0};
    endcase
    return r;
  endfunction

endpackage

// ===== design/tnt_dp.sv =====
// Datapath: corner store, serial multiply-accumulate, normalize, square root and divide
module tnt_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int UNIT_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic [COORD_WIDTH-1:0] in_pos_x,
  input  logic [COORD_WIDTH-1:0] in_pos_y,
  input  logic [COORD_WIDTH-1:0] in_pos_z,
  input  logic [COORD_WIDTH-1:0] in_tex_u,
  input  logic [COORD_WIDTH-1:0] in_tex_v,
  input  tnt_pkg::cmd_t          cmd,
  output tnt_pkg::sts_t          sts,
  output logic [UNIT_WIDTH-1:0]  out_normal_x,
  output logic [UNIT_WIDTH-1:0]  out_normal_y,
  output logic [UNIT_WIDTH-1:0]  out_normal_z,
  output logic [UNIT_WIDTH-1:0]  out_tangent_x,
  output logic [UNIT_WIDTH-1:0]  out_tangent_y,
  output logic [UNIT_WIDTH-1:0]  out_tangent_z,
  output logic [1:0]             out_status
);
  import tnt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int UW    = UNIT_WIDTH;
  localparam int EW    = CW + 1;
  localparam int PW    = 2 * EW + 1;
  localparam int MW    = PW - 1;
  localparam int F     = UW - 2;
  localparam int NB    = F + C_W + 1;
  localparam int REM_W = LEN_W + 1;

  logic [CW-1:0] p0_r [3];
  logic [CW-1:0] p1_r [3];
  logic [CW-1:0] u0_r, v0_r, u1_r, v1_r;
  logic [EW-1:0] opnd_r [OPD_N];
  logic [PW-1:0] acc_r [ACC_N];
  logic [MW-1:0] mcand_r;
  logic [EW-1:0] mplier_r;
  logic          msub_r;
  logic [2:0]    mdst_r;
  logic [MW-1:0] mag_r [3];
  logic          neg_r [3];
  logic [SQ_W-1:0] sum_r, sqx_r, sqr_r, bit_r;
  logic [NB-1:0]   num_r;
  logic [REM_W-1:0] rem_r;
  logic [UW-1:0]   q_r;
  logic [UW-1:0]   res_r [6];
  logic [UW-1:0]   onx_r, ony_r, onz_r, otx_r, oty_r, otz_r;
  logic [1:0]      ost_r;

  function automatic logic [EW-1:0] sx(input logic [CW-1:0] x);
    return {x[CW-1], x};
  endfunction

  function automatic logic [EW-1:0] absw(input logic [EW-1:0] x);
    return x[EW-1] ? (~x + 1'b1) : x;
  endfunction

  opinfo_t       info;
  logic [EW-1:0] opa, opb;
  logic          to_tan;
  logic [PW-1:0] mc_ext;
  logic [MW-1:0] nmag [3];
  logic          nneg [3];
  logic [MW-1:0] mag_or;
  logic [C_W-1:0] sq_c;
  logic [2*C_W-1:0] sq_prod;
  logic [SQ_W-1:0]  sq_try;
  logic [LEN_W-1:0] len;
  logic [REM_W-1:0] rem_sh;
  logic             qbit;
  logic [C_W-1:0]   div_c;
  logic [UW-1:0]    q_signed;
  logic [2:0]       vbase;
  logic [2:0]       ridx;

  always_comb begin
    info   = op_info(cmd.op);
    opa    = opnd_r[info.a];
    opb    = opnd_r[info.b];
    to_tan = (info.dst == ACC_TGX) || (info.dst == ACC_TGY) || (info.dst == ACC_TGZ);
    mc_ext = {1'b0, mcand_r};
    vbase  = cmd.vsel ? 3'd3 : 3'd0;
    for (int i = 0; i < 3; i++) begin
      nneg[i] = acc_r[vbase + 3'(i)][PW-1];
      nmag[i] = nneg[i] ? MW'(~acc_r[vbase + 3'(i)] + 1'b1) : acc_r[vbase + 3'(i)][MW-1:0];
    end
    mag_or  = mag_r[0] | mag_r[1] | mag_r[2];
    sq_c    = mag_r[cmd.idx][C_W-1:0];
    sq_prod = sq_c * sq_c;
    sq_try  = sqr_r + bit_r;
    len     = sqr_r[LEN_W-1:0];
    rem_sh  = {rem_r[REM_W-2:0], num_r[NB-1]};
    qbit    = rem_sh >= {1'b0, len};
    div_c   = mag_r[cmd.idx][C_W-1:0];
    q_signed = neg_r[cmd.idx] ? (~q_r + 1'b1) : q_r;
    ridx    = vbase + {1'b0, cmd.idx};
  end

  assign sts.det_zero  = acc_r[ACC_DET] == '0;
  assign sts.det_neg   = acc_r[ACC_DET][PW-1];
  assign sts.norm_zero = mag_or == '0;
  assign sts.norm_hi   = |mag_or[MW-1:NORM_HI_BIT];
  assign sts.norm_lo   = ~|mag_or[MW-1:NORM_LO_BIT];

  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      p0_r[0] <= in_pos_x;
      p0_r[1] <= in_pos_y;
      p0_r[2] <= in_pos_z;
      u0_r    <= in_tex_u;
      v0_r    <= in_tex_v;
    end
    if (cmd.cap1) begin
      p1_r[0] <= in_pos_x;
      p1_r[1] <= in_pos_y;
      p1_r[2] <= in_pos_z;
      u1_r    <= in_tex_u;
      v1_r    <= in_tex_v;
    end
    if (cmd.cap2) begin
      opnd_r[OPD_E1X] <= sx(p1_r[0]) - sx(p0_r[0]);
      opnd_r[OPD_E1Y] <= sx(p1_r[1]) - sx(p0_r[1]);
      opnd_r[OPD_E1Z] <= sx(p1_r[2]) - sx(p0_r[2]);
      opnd_r[OPD_E2X] <= sx(in_pos_x) - sx(p0_r[0]);
      opnd_r[OPD_E2Y] <= sx(in_pos_y) - sx(p0_r[1]);
      opnd_r[OPD_E2Z] <= sx(in_pos_z) - sx(p0_r[2]);
      opnd_r[OPD_DU1] <= sx(u1_r) - sx(u0_r);
      opnd_r[OPD_DV1] <= sx(v1_r) - sx(v0_r);
      opnd_r[OPD_DU2] <= sx(in_tex_u) - sx(u0_r);
      opnd_r[OPD_DV2] <= sx(in_tex_v) - sx(v0_r);
      for (int i = 0; i < ACC_N; i++) acc_r[i] <= '0;
      for (int i = 0; i < 6; i++) res_r[i] <= '0;
    end
    if (cmd.mac_load) begin
      mcand_r  <= {{(MW-EW){1'b0}}, absw(opa)};
      mplier_r <= absw(opb);
      msub_r   <= opa[EW-1] ^ opb[EW-1] ^ info.sub ^ (to_tan & sts.det_neg);
      mdst_r   <= info.dst;
    end
    if (cmd.mac_step) begin
      if (mplier_r[0]) begin
        acc_r[mdst_r] <= msub_r ? (acc_r[mdst_r] - mc_ext) : (acc_r[mdst_r] + mc_ext);
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.norm_load) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= nmag[i];
        neg_r[i] <= nneg[i];
      end
      sum_r <= '0;
    end
    if (cmd.norm_shr) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
    end
    if (cmd.norm_shl) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
    end
    if (cmd.sq_step) begin
      sum_r <= sum_r + {{(SQ_W-2*C_W){1'b0}}, sq_prod};
    end
    if (cmd.sqrt_init) begin
      sqx_r <= sum_r;
      sqr_r <= '0;
      bit_r <= {2'b01, {(SQ_W-2){1'b0}}};
    end
    if (cmd.sqrt_step) begin
      if (sqx_r >= sq_try) begin
        sqx_r <= sqx_r - sq_try;
        sqr_r <= (sqr_r >> 1) + bit_r;
      end else begin
        sqr_r <= sqr_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_load) begin
      num_r <= {1'b0, div_c, {F{1'b0}}} + {{(NB-LEN_W+1){1'b0}}, len[LEN_W-1:1]};
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? (rem_sh - {1'b0, len}) : rem_sh;
      num_r <= num_r << 1;
      q_r   <= {q_r[UW-2:0], qbit};
    end
    if (cmd.div_store) begin
      res_r[ridx] <= q_signed;
    end
    if (cmd.out_load) begin
      onx_r <= res_r[0];
      ony_r <= res_r[1];
      onz_r <= res_r[2];
      otx_r <= res_r[3];
      oty_r <= res_r[4];
      otz_r <= res_r[5];
      ost_r <= cmd.status;
    end
  end

  assign out_normal_x  = onx_r;
  assign out_normal_y  = ony_r;
  assign out_normal_z  = onz_r;
  assign out_tangent_x = otx_r;
  assign out_tangent_y = oty_r;
  assign out_tangent_z = otz_r;
  assign out_status    = ost_r;

endmodule

// ===== design/tnt_ctrl.sv =====
// Controller: corner counting, operation sequencing and output handshake
`include "triangle_normal_tangent_core_defines.svh"

module tnt_ctrl #(
  parameter int COORD_WIDTH = 32,
  parameter int UNIT_WIDTH  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  tnt_pkg::sts_t sts,
  output tnt_pkg::cmd_t cmd
);
  import tnt_pkg::*;

  localparam int EW    = COORD_WIDTH + 1;
  localparam int NB    = UNIT_WIDTH - 2 + C_W + 1;
  localparam int MAXN  = (EW > NB) ? ((EW > SQRT_STEPS) ? EW : SQRT_STEPS)
                                   : ((NB > SQRT_STEPS) ? NB : SQRT_STEPS);
  localparam int CNT_W = $clog2(MAXN);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAC_LD = 4'd1;
  localparam logic [3:0] S_MAC    = 4'd2;
  localparam logic [3:0] S_NLD    = 4'd3;
  localparam logic [3:0] S_NCHK   = 4'd4;
  localparam logic [3:0] S_NSHIFT = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_SQI    = 4'd7;
  localparam logic [3:0] S_SQRT   = 4'd8;
  localparam logic [3:0] S_DLD    = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_DST    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       corner_r, corner_nxt;
  logic             cfg_r, cfg_nxt;
  logic             tan_en_r, tan_en_nxt;
  logic [3:0]       op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             vsel_r, vsel_nxt;
  logic             area0_r, area0_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             more_vec;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign more_vec   = !vsel_r && tan_en_r && !sts.det_zero;

  always_comb begin
    state_nxt     = state_r;
    corner_nxt    = corner_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    tan_en_nxt    = tan_en_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    vsel_nxt      = vsel_r;
    area0_nxt     = area0_r;
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.idx       = idx_r;
    cmd.vsel      = vsel_r;
    cmd.status    = (tan_en_r && sts.det_zero ? ST_DET_ZERO : 2'b00) |
                    (area0_r ? ST_AREA_ZERO : 2'b00);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (corner_r)
            2'd0: begin
              cmd.cap0   = 1'b1;
              corner_nxt = 2'd1;
            end
            2'd1: begin
              cmd.cap1   = 1'b1;
              corner_nxt = 2'd2;
            end
            default: begin
              cmd.cap2   = 1'b1;
              corner_nxt = 2'd0;
              tan_en_nxt = cfg_r;
              op_nxt     = cfg_r ? OP_FIRST_DET : OP_FIRST_CROSS;
              area0_nxt  = 1'b0;
              vsel_nxt   = 1'b0;
              state_nxt  = S_MAC_LD;
            end
          endcase
        end
      end
      S_MAC_LD: begin
        cmd.mac_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_MAC;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(EW - 1)) begin
          if (op_r == OP_LAST_CROSS) begin
            if (tan_en_r && !sts.det_zero) begin
              op_nxt    = OP_FIRST_TAN;
              state_nxt = S_MAC_LD;
            end else begin
              state_nxt = S_NLD;
            end
          end else if (op_r == OP_LAST_TAN) begin
            state_nxt = S_NLD;
          end else begin
            op_nxt    = op_r + 1'b1;
            state_nxt = S_MAC_LD;
          end
        end
      end
      S_NLD: begin
        cmd.norm_load = 1'b1;
        state_nxt     = S_NCHK;
      end
      S_NCHK: begin
        if (sts.norm_zero) begin
          if (!vsel_r) area0_nxt = 1'b1;
          if (more_vec) begin
            vsel_nxt  = 1'b1;
            state_nxt = S_NLD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_NSHIFT;
        end
      end
      S_NSHIFT: begin
        if (sts.norm_hi) begin
          cmd.norm_shr = 1'b1;
        end else if (sts.norm_lo) begin
          cmd.norm_shl = 1'b1;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == 2'd2) state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          idx_nxt   = 2'd0;
          state_nxt = S_DLD;
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NB - 1)) state_nxt = S_DST;
      end
      S_DST: begin
        cmd.div_store = 1'b1;
        if (idx_r == 2'd2) begin
          if (more_vec) begin
            vsel_nxt  = 1'b1;
            state_nxt = S_NLD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DLD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      corner_r    <= 2'd0;
      cfg_r       <= 1'b1;
      tan_en_r    <= 1'b0;
      op_r        <= OP_FIRST_DET;
      cnt_r       <= '0;
      idx_r       <= 2'd0;
      vsel_r      <= 1'b0;
      area0_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      corner_r    <= corner_nxt;
      cfg_r       <= cfg_nxt;
      tan_en_r    <= tan_en_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      vsel_r      <= vsel_nxt;
      area0_r     <= area0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TNT_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "reset state")
  `TNT_ASSERT(a_third_starts, (in_tvalid && in_tready && corner_r == 2'd2) |=> (state_r == S_MAC_LD), "third corner must start triangle")
  `TNT_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_tready), "result overwritten")
  `TNT_ASSERT(a_tan_vec_gate, (state_r == S_NLD && vsel_r) |-> (tan_en_r && !sts.det_zero), "tangent normalized when disabled")
  `TNT_ASSERT(a_mac_follows, cmd.mac_load |=> (state_r == S_MAC && cnt_r == '0), "mac load not followed by steps")

endmodule

// ===== design/triangle_normal_tangent_core.sv =====
// Top level of the triangle face normal and tangent core
//
// Input stream: one vertex per beat, pos_x/y/z and tex_u/v in signed Q16.16.
// Every third beat closes a triangle and yields one output beat with the unit
// face normal, the unit tangent (zero when calc_tangent is 0) in Q2.14 and a
// 2-bit status (bit 0 zero area, bit 1 zero UV determinant).
// The first two corners of a triangle are only stored. The third
// starts a sequence on one shared bit-serial multiply-accumulate unit, a shift
// normalizer, a bit-per-cycle square root and a bit-per-cycle divider; the
// input is not ready until that sequence ends. It forms 6, 8 or 14 products
// on that unit, then for each nonzero vector scales the components, takes the
// square root of their sum of squares and divides each of the 3 components
// by it.
// The result sits in an output register; while the receiver stalls the block
// still accepts new corners and computes the next triangle, holding it until
// the pending beat is taken. Reset (rst_n low, synchronous) drops any pending
// beat, clears the corner count and sets calc_tangent to 1.
module triangle_normal_tangent_core #(
  parameter int COORD_WIDTH = 32,
  parameter int UNIT_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z, status, zero pad
  output logic [((6*UNIT_WIDTH+2+7)/8)*8-1:0] out_tdata,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import tnt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int UW    = UNIT_WIDTH;
  localparam int OUT_W = ((6*UW+2+7)/8)*8;

  cmd_t          cmd;
  sts_t          sts;
  logic [UW-1:0] nx, ny, nz, tx, ty, tz;
  logic [1:0]    st;

  tnt_ctrl #(
    .COORD_WIDTH(COORD_WIDTH),
    .UNIT_WIDTH (UNIT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  tnt_dp #(
    .COORD_WIDTH(COORD_WIDTH),
    .UNIT_WIDTH (UNIT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .in_pos_x     (in_tdata[CW-1:0]),
    .in_pos_y     (in_tdata[2*CW-1:CW]),
    .in_pos_z     (in_tdata[3*CW-1:2*CW]),
    .in_tex_u     (in_tdata[4*CW-1:3*CW]),
    .in_tex_v     (in_tdata[5*CW-1:4*CW]),
    .cmd          (cmd),
    .sts          (sts),
    .out_normal_x (nx),
    .out_normal_y (ny),
    .out_normal_z (nz),
    .out_tangent_x(tx),
    .out_tangent_y(ty),
    .out_tangent_z(tz),
    .out_status   (st)
  );

  assign out_tdata = {{(OUT_W-6*UW-2){1'b0}}, st, tz, ty, tx, nz, ny, nx};

endmodule

// ===== sim/tb.sv =====
// Testbench for triangle_normal_tangent_core: random vertex stream checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int UW = 16;
  localparam int IN_W = ((5*CW+7)/8)*8;
  localparam int OUT_W = ((6*UW+2+7)/8)*8;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] status;
    logic [UW-1:0] tz, ty, tx, nz, ny, nx;
  } face_t;

  class face_board;
    logic [CW-1:0] pos[2][3];
    logic [CW-1:0] tex[2][2];
    int corner;
    bit tangent_on;
    face_t pending[$];
    int errors;

    function void clear();
      corner = 0;
      tangent_on = 1;
      pending.delete();
      errors = 0;
    endfunction

    function automatic logic [UW-1:0] unit_comp(logic [63:0] c, logic [31:0] len, bit neg);
      logic [63:0] q;
      q = ((c << (UW-2)) + (len >> 1)) / len;
      return neg ? -q[UW-1:0] : q[UW-1:0];
    endfunction

    function automatic logic [31:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r[31:0];
    endfunction

    // returns 0 for the zero vector
    function automatic bit unit_vec(logic signed [127:0] v[3], output logic [UW-1:0] o[3]);
      logic [127:0] m[3];
      logic [63:0] c[3], sum;
      logic [31:0] len;
      int bl, mx;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        bl = 0;
        for (int b = 0; b < 128; b++) if (m[i][b]) bl = b + 1;
        if (bl > mx) mx = bl;
      end
      if (mx == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return 0;
      end
      for (int i = 0; i < 3; i++) begin
        if (mx > 30) c[i] = 64'(m[i] >> (mx - 30)) & 64'h3FFF_FFFF;
        else c[i] = 64'(m[i]) << (30 - mx);
        sum += c[i] * c[i];
      end
      len = root(sum);
      for (int i = 0; i < 3; i++) o[i] = unit_comp(c[i], len, v[i] < 0);
      return 1;
    endfunction

    function void note_vertex(logic [IN_W-1:0] d);
      logic signed [63:0] p[3], e1[3], e2[3], du1, dv1, du2, dv2, u, v;
      logic signed [127:0] cr[3], tg[3], det;
      logic [UW-1:0] n[3], t[3];
      face_t f;
      for (int i = 0; i < 3; i++) p[i] = 64'(signed'(d[i*CW +: CW]));
      u = 64'(signed'(d[3*CW +: CW]));
      v = 64'(signed'(d[4*CW +: CW]));
      if (corner < 2) begin
        for (int i = 0; i < 3; i++) pos[corner][i] = p[i][CW-1:0];
        tex[corner][0] = u[CW-1:0];
        tex[corner][1] = v[CW-1:0];
        corner++;
        return;
      end
      corner = 0;
      f = '0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = 64'(signed'(pos[1][i])) - 64'(signed'(pos[0][i]));
        e2[i] = p[i] - 64'(signed'(pos[0][i]));
      end
      cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
      cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
      cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
      if (!unit_vec(cr, n)) f.status[0] = 1;
      t[0] = 0; t[1] = 0; t[2] = 0;
      if (tangent_on) begin
        du1 = 64'(signed'(tex[1][0])) - 64'(signed'(tex[0][0]));
        dv1 = 64'(signed'(tex[1][1])) - 64'(signed'(tex[0][1]));
        du2 = u - 64'(signed'(tex[0][0]));
        dv2 = v - 64'(signed'(tex[0][1]));
        det = 128'(du1) * 128'(dv2) - 128'(du2) * 128'(dv1);
        if (det == 0) begin
          f.status[1] = 1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            tg[i] = 128'(dv2) * 128'(e1[i]) - 128'(dv1) * 128'(e2[i]);
            if (det < 0) tg[i] = -tg[i];
          end
          void'(unit_vec(tg, t));
        end
      end
      f.nx = n[0]; f.ny = n[1]; f.nz = n[2];
      f.tx = t[0]; f.ty = t[1]; f.tz = t[2];
      pending = {pending, f};
    endfunction

    function void check_face(logic [OUT_W-1:0] d);
      face_t a, e;
      a = d[6*UW+1:0];
      if (pending.size() == 0) begin
        $error("unexpected output beat %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.nx !== e.nx) begin $error("normal_x exp %h got %h", e.nx, a.nx); errors++; end
      if (a.ny !== e.ny) begin $error("normal_y exp %h got %h", e.ny, a.ny); errors++; end
      if (a.nz !== e.nz) begin $error("normal_z exp %h got %h", e.nz, a.nz); errors++; end
      if (a.tx !== e.tx) begin $error("tangent_x exp %h got %h", e.tx, a.tx); errors++; end
      if (a.ty !== e.ty) begin $error("tangent_y exp %h got %h", e.ty, a.ty); errors++; end
      if (a.tz !== e.tz) begin $error("tangent_z exp %h got %h", e.tz, a.tz); errors++; end
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 0, cfg_wdata = 0;
  face_board sb;
  int cycles = 0;
  bit hold_off = 0;

  triangle_normal_tangent_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) sb.note_vertex(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_face(out_tdata);
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) out_tready <= 0;
    else if ((cycles / 500) % 3 == 2) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'(signed'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vertex(logic [CW-1:0] x, y, z, u, v);
    in_tdata <= IN_W'({v, u, z, y, x});
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_random_tri(bit degenerate);
    logic [CW-1:0] a[5], b[5];
    for (int i = 0; i < 5; i++) begin
      a[i] = rand_coord();
      b[i] = rand_coord();
    end
    send_vertex(a[0], a[1], a[2], a[3], a[4]);
    send_vertex(b[0], b[1], b[2], b[3], b[4]);
    if (degenerate && $urandom_range(0, 1)) send_vertex(a[0], a[1], a[2], rand_coord(), rand_coord());
    else if (degenerate) send_vertex(rand_coord(), rand_coord(), rand_coord(), a[3], a[4]);
    else send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain_and_config(bit val);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.tangent_on = val;
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, zero area, zero uv det, unit triangle
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h1_0000, 0, 0, 32'h1_0000, 0);
    send_vertex(0, 32'h1_0000, 0, 0, 32'h1_0000);
    send_vertex(5, 5, 5, 1, 1);
    send_vertex(5, 5, 5, 2, 2);
    send_vertex(5, 5, 5, 3, 3);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vertex(0, 32'hFFFF_FFFF, 0, 0, 0);
    send_vertex(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    drain_and_config(0);
    send_random_tri(0);
    send_random_tri(1);
    drain_and_config(1);
    // long receiver hold-off while vertices keep coming
    fork
      begin
        hold_off = 1;
        repeat (6000) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_random_tri(0);
    join
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 85; i++) send_random_tri($urandom_range(0, 9) == 0);
      drain_and_config(ph[0]);
    end
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
